### rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checks that one condition is followed by another on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error(msg);

`endif

### rtl/vfa_pkg.sv
package vfa_pkg;

	localparam int COMP_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int PROD_W    = 2 * COMP_W;
	localparam int SUM_W     = PROD_W + 2;
	localparam int WIDE_W    = PROD_W + 4;
	localparam int ROOT_W    = SUM_W / 2;
	localparam int SQ_STEPS  = ROOT_W;
	localparam int SQ_REM_W  = ROOT_W + 3;
	localparam int NUM_W     = COMP_W + FRAC_W;
	localparam int DIV_STEPS = NUM_W;
	localparam int DEN_W     = ROOT_W;
	localparam int REM_W     = DEN_W + 1;
	localparam int LANES     = 3;

	localparam logic signed [WIDE_W-1:0] SAT_MAX =
		{{(WIDE_W-COMP_W+1){1'b0}}, {(COMP_W-1){1'b1}}};
	localparam logic signed [WIDE_W-1:0] SAT_MIN =
		{{(WIDE_W-COMP_W+1){1'b1}}, {(COMP_W-1){1'b0}}};

	typedef enum logic [3:0] {
		MODE_ADD   = 4'd0,
		MODE_SUB   = 4'd1,
		MODE_CROSS = 4'd2,
		MODE_DOT   = 4'd3,
		MODE_SCALE = 4'd4,
		MODE_DIV   = 4'd5,
		MODE_NEG   = 4'd6,
		MODE_CMP   = 4'd7,
		MODE_NORM  = 4'd8,
		MODE_LEN   = 4'd9
	} mode_t;

	typedef logic signed [COMP_W-1:0] comp_t;

	typedef struct packed {
		logic [3:0]                    mode;
		logic [LANES-1:0][COMP_W-1:0]  a;
		logic [COMP_W-1:0]             f;
		logic [LANES-1:0][COMP_W-1:0]  res;
		logic [COMP_W-1:0]             scalar;
		logic                          eq;
		logic [ROOT_W-1:0]             root;
	} side_t;

	typedef struct packed {
		logic [LANES-1:0][COMP_W-1:0]  r;
		logic [COMP_W-1:0]             scalar;
		logic                          eq;
		logic                          derr;
	} res_t;

	function automatic comp_t sat_c(input logic signed [WIDE_W-1:0] x);
		comp_t y;
		if (x < SAT_MIN) begin
			y = SAT_MIN[COMP_W-1:0];
		end else if (x > SAT_MAX) begin
			y = SAT_MAX[COMP_W-1:0];
		end else begin
			y = x[COMP_W-1:0];
		end
		return y;
	endfunction

endpackage

### rtl/vfa_lane.sv
module vfa_lane (
	input  logic                                clk,
	input  logic                                en,
	input  logic [3:0]                          mode,
	input  logic signed [vfa_pkg::COMP_W-1:0]   a_i,
	input  logic signed [vfa_pkg::COMP_W-1:0]   b_i,
	input  logic signed [vfa_pkg::COMP_W-1:0]   a_j,
	input  logic signed [vfa_pkg::COMP_W-1:0]   a_k,
	input  logic signed [vfa_pkg::COMP_W-1:0]   b_j,
	input  logic signed [vfa_pkg::COMP_W-1:0]   b_k,
	input  logic signed [vfa_pkg::COMP_W-1:0]   fac,
	output logic signed [vfa_pkg::PROD_W-1:0]   prod_s2,
	output logic                                eq_s2,
	output logic signed [vfa_pkg::COMP_W-1:0]   res_s3
);

	logic signed [vfa_pkg::COMP_W-1:0] m0a;
	logic signed [vfa_pkg::COMP_W-1:0] m0b;
	logic signed [vfa_pkg::COMP_W-1:0] simple;
	logic signed [vfa_pkg::COMP_W-1:0] simple_s2;
	logic signed [vfa_pkg::PROD_W-1:0] p1_s2;
	logic [3:0]                        mode_s2;
	logic signed [vfa_pkg::WIDE_W-1:0] wide;

	always_comb begin
		m0a    = a_i;
		m0b    = b_i;
		simple = '0;
		case (mode) inside
			vfa_pkg::MODE_CROSS: begin
				m0a = a_j;
				m0b = b_k;
			end
			vfa_pkg::MODE_SCALE: begin
				m0a = fac;
				m0b = a_i;
			end
			vfa_pkg::MODE_NORM, vfa_pkg::MODE_LEN: begin
				m0b = a_i;
			end
			vfa_pkg::MODE_ADD: begin
				simple = vfa_pkg::sat_c(vfa_pkg::WIDE_W'(a_i) + vfa_pkg::WIDE_W'(b_i));
			end
			vfa_pkg::MODE_SUB: begin
				simple = vfa_pkg::sat_c(vfa_pkg::WIDE_W'(a_i) - vfa_pkg::WIDE_W'(b_i));
			end
			vfa_pkg::MODE_NEG: begin
				simple = vfa_pkg::sat_c(-vfa_pkg::WIDE_W'(a_i));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2   <= m0a * m0b;
			p1_s2     <= a_k * b_j;
			simple_s2 <= simple;
			mode_s2   <= mode;
			eq_s2     <= (a_i == b_i);
		end
	end

	always_comb begin
		if (mode_s2 == vfa_pkg::MODE_CROSS) begin
			wide = vfa_pkg::WIDE_W'(prod_s2) - vfa_pkg::WIDE_W'(p1_s2);
		end else begin
			wide = vfa_pkg::WIDE_W'(prod_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (mode_s2) inside
				vfa_pkg::MODE_CROSS, vfa_pkg::MODE_SCALE: begin
					res_s3 <= vfa_pkg::sat_c(wide >>> vfa_pkg::FRAC_W);
				end
				vfa_pkg::MODE_ADD, vfa_pkg::MODE_SUB, vfa_pkg::MODE_NEG: begin
					res_s3 <= simple_s2;
				end
				default: begin
					res_s3 <= '0;
				end
			endcase
		end
	end

endmodule

### rtl/vfa_isqrt.sv
module vfa_isqrt (
	input  logic                          clk,
	input  logic                          en,
	input  logic [vfa_pkg::SUM_W-1:0]     radicand,
	output logic [vfa_pkg::ROOT_W-1:0]    root
);

	logic [vfa_pkg::SQ_REM_W-1:0] rem_q  [vfa_pkg::SQ_STEPS-1];
	logic [vfa_pkg::SUM_W-1:0]    x_q    [vfa_pkg::SQ_STEPS-1];
	logic [vfa_pkg::ROOT_W-1:0]   root_q [vfa_pkg::SQ_STEPS];

	for (genvar k = 0; k < vfa_pkg::SQ_STEPS; k++) begin : g_st
		logic [vfa_pkg::SQ_REM_W-1:0] rem_in;
		logic [vfa_pkg::SQ_REM_W-1:0] rem_try;
		logic [vfa_pkg::SQ_REM_W-1:0] trial;
		logic [vfa_pkg::SQ_REM_W-1:0] rem_nx;
		logic [vfa_pkg::ROOT_W-1:0]   root_in;
		logic [vfa_pkg::ROOT_W-1:0]   root_nx;
		logic [vfa_pkg::SUM_W-1:0]    x_in;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign x_in    = radicand;
		end else begin : g_next
			assign rem_in  = rem_q[k-1];
			assign root_in = root_q[k-1];
			assign x_in    = x_q[k-1];
		end

		always_comb begin
			rem_try = {rem_in[vfa_pkg::SQ_REM_W-3:0], x_in[vfa_pkg::SUM_W-1 -: 2]};
			trial   = {1'b0, root_in, 2'b01};
			if (rem_try >= trial) begin
				rem_nx  = rem_try - trial;
				root_nx = {root_in[vfa_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_nx  = rem_try;
				root_nx = {root_in[vfa_pkg::ROOT_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_q[k] <= root_nx;
			end
		end

		if (k < vfa_pkg::SQ_STEPS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k] <= rem_nx;
					x_q[k]   <= x_in << 2;
				end
			end
		end
	end

	assign root = root_q[vfa_pkg::SQ_STEPS-1];

endmodule

### rtl/vfa_div.sv
module vfa_div (
	input  logic                              clk,
	input  logic                              en,
	input  logic [vfa_pkg::NUM_W-1:0]         num,
	input  logic [vfa_pkg::DEN_W-1:0]         den,
	input  logic                              neg,
	output logic signed [vfa_pkg::COMP_W-1:0] quot
);

	logic [vfa_pkg::REM_W-1:0] rem_q [vfa_pkg::DIV_STEPS-1];
	logic [vfa_pkg::DEN_W-1:0] den_q [vfa_pkg::DIV_STEPS-1];
	logic [vfa_pkg::NUM_W-1:0] nq_q  [vfa_pkg::DIV_STEPS];
	logic                      neg_q [vfa_pkg::DIV_STEPS];
	logic signed [vfa_pkg::NUM_W:0] qs;

	for (genvar k = 0; k < vfa_pkg::DIV_STEPS; k++) begin : g_st
		logic [vfa_pkg::REM_W-1:0] rem_in;
		logic [vfa_pkg::REM_W-1:0] rem_try;
		logic [vfa_pkg::REM_W-1:0] rem_nx;
		logic [vfa_pkg::DEN_W-1:0] den_in;
		logic [vfa_pkg::NUM_W-1:0] nq_in;
		logic                      neg_in;
		logic                      qbit;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign den_in = den;
			assign nq_in  = num;
			assign neg_in = neg;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign den_in = den_q[k-1];
			assign nq_in  = nq_q[k-1];
			assign neg_in = neg_q[k-1];
		end

		always_comb begin
			rem_try = {rem_in[vfa_pkg::REM_W-2:0], nq_in[vfa_pkg::NUM_W-1]};
			if (rem_try >= {1'b0, den_in}) begin
				rem_nx = rem_try - {1'b0, den_in};
				qbit   = 1'b1;
			end else begin
				rem_nx = rem_try;
				qbit   = 1'b0;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nq_q[k]  <= {nq_in[vfa_pkg::NUM_W-2:0], qbit};
				neg_q[k] <= neg_in;
			end
		end

		if (k < vfa_pkg::DIV_STEPS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k] <= rem_nx;
					den_q[k] <= den_in;
				end
			end
		end
	end

	always_comb begin
		if (neg_q[vfa_pkg::DIV_STEPS-1]) begin
			qs = -$signed({1'b0, nq_q[vfa_pkg::DIV_STEPS-1]});
		end else begin
			qs = $signed({1'b0, nq_q[vfa_pkg::DIV_STEPS-1]});
		end
		quot = vfa_pkg::sat_c(vfa_pkg::WIDE_W'(qs));
	end

endmodule

### rtl/vector3_fixed_point_alu.sv
// Three-component vector unit on signed Q16.16 numbers.
// The input channel (in_valid, in_stall) carries one item: a mode, vectors a and b
// and a scalar factor. The output channel (out_valid, out_stall) returns exactly
// one result item per input item, in order.
// The path is a fixed pipeline: three lanes of multipliers, one merge stage for the
// sum, a 33-stage square root, then three 48-stage dividers, one quotient bit per
// stage.
// Throughput is one item per cycle whatever the mode, while no stall freezes the pipeline.
// When the receiver stalls, the finished item holds in the output register and the
// next one lands in a skid register; only then does in_stall rise and the whole
// pipeline freeze until the output is taken.
// Reset clears all valid bits, so no item is in flight after reset; the data
// registers are not reset.
`include "assert_macros.svh"

module vector3_fixed_point_alu (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [3:0]                          mode,
	input  logic signed [vfa_pkg::COMP_W-1:0]   a_x,
	input  logic signed [vfa_pkg::COMP_W-1:0]   a_y,
	input  logic signed [vfa_pkg::COMP_W-1:0]   a_z,
	input  logic signed [vfa_pkg::COMP_W-1:0]   b_x,
	input  logic signed [vfa_pkg::COMP_W-1:0]   b_y,
	input  logic signed [vfa_pkg::COMP_W-1:0]   b_z,
	input  logic signed [vfa_pkg::COMP_W-1:0]   factor,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [vfa_pkg::COMP_W-1:0]   r_x,
	output logic signed [vfa_pkg::COMP_W-1:0]   r_y,
	output logic signed [vfa_pkg::COMP_W-1:0]   r_z,
	output logic signed [vfa_pkg::COMP_W-1:0]   scalar_out,
	output logic                                equal_flag,
	output logic                                div_error
);

	localparam int NL = vfa_pkg::LANES;

	logic en;

	logic                      vld_s1, vld_s2, vld_s3;
	logic [3:0]                mode_s1, mode_s2, mode_s3;
	vfa_pkg::comp_t            a_s1 [NL];
	vfa_pkg::comp_t            b_s1 [NL];
	vfa_pkg::comp_t            a_s2 [NL];
	vfa_pkg::comp_t            a_s3 [NL];
	vfa_pkg::comp_t            f_s1, f_s2, f_s3;
	logic                      eq_s3;
	logic signed [vfa_pkg::SUM_W-1:0] sum_s3;

	logic signed [vfa_pkg::PROD_W-1:0] lane_prod [NL];
	logic                              lane_eq   [NL];
	vfa_pkg::comp_t                    lane_res  [NL];

	vfa_pkg::side_t            side0;
	vfa_pkg::side_t            sq_side_q [vfa_pkg::SQ_STEPS];
	logic [vfa_pkg::SQ_STEPS-1:0] sq_vld_q;
	logic [vfa_pkg::ROOT_W-1:0] root;
	vfa_pkg::side_t            side_d;
	logic signed [vfa_pkg::DEN_W-1:0] fx;
	logic [vfa_pkg::DEN_W-1:0] den;
	vfa_pkg::side_t            dv_side_q [vfa_pkg::DIV_STEPS];
	logic [vfa_pkg::DIV_STEPS-1:0] dv_vld_q;
	vfa_pkg::comp_t            quot [NL];

	vfa_pkg::side_t            side_f;
	vfa_pkg::res_t             fin;
	logic                      produce;
	vfa_pkg::res_t             out_q, skid_q;
	logic                      out_vld_q, skid_vld_q;

	assign en       = !skid_vld_q;
	assign in_stall = skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			sq_vld_q <= '0;
			dv_vld_q <= '0;
		end else if (en) begin
			vld_s1   <= in_valid;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			sq_vld_q <= {sq_vld_q[vfa_pkg::SQ_STEPS-2:0], vld_s3};
			dv_vld_q <= {dv_vld_q[vfa_pkg::DIV_STEPS-2:0], sq_vld_q[vfa_pkg::SQ_STEPS-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			a_s1[0] <= a_x;
			a_s1[1] <= a_y;
			a_s1[2] <= a_z;
			b_s1[0] <= b_x;
			b_s1[1] <= b_y;
			b_s1[2] <= b_z;
			f_s1    <= factor;
			mode_s2 <= mode_s1;
			mode_s3 <= mode_s2;
			a_s2    <= a_s1;
			a_s3    <= a_s2;
			f_s2    <= f_s1;
			f_s3    <= f_s2;
			eq_s3   <= lane_eq[0] && lane_eq[1] && lane_eq[2];
			sum_s3  <= vfa_pkg::SUM_W'(lane_prod[0]) + vfa_pkg::SUM_W'(lane_prod[1])
				+ vfa_pkg::SUM_W'(lane_prod[2]);
		end
	end

	for (genvar i = 0; i < NL; i++) begin : g_lane
		vfa_lane u_lane (
			.clk     (clk),
			.en      (en),
			.mode    (mode_s1),
			.a_i     (a_s1[i]),
			.b_i     (b_s1[i]),
			.a_j     (a_s1[(i+1)%NL]),
			.a_k     (a_s1[(i+2)%NL]),
			.b_j     (b_s1[(i+1)%NL]),
			.b_k     (b_s1[(i+2)%NL]),
			.fac     (f_s1),
			.prod_s2 (lane_prod[i]),
			.eq_s2   (lane_eq[i]),
			.res_s3  (lane_res[i])
		);
	end

	always_comb begin
		side0        = '0;
		side0.mode   = mode_s3;
		side0.f      = f_s3;
		for (int i = 0; i < NL; i++) begin
			side0.a[i]   = a_s3[i];
			side0.res[i] = lane_res[i];
		end
		if (mode_s3 == vfa_pkg::MODE_DOT) begin
			side0.scalar = vfa_pkg::sat_c(vfa_pkg::WIDE_W'(sum_s3) >>> vfa_pkg::FRAC_W);
		end
		side0.eq = (mode_s3 == vfa_pkg::MODE_CMP) && eq_s3;
	end

	vfa_isqrt u_isqrt (
		.clk      (clk),
		.en       (en),
		.radicand (sum_s3),
		.root     (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_side_q[0] <= side0;
			for (int k = 1; k < vfa_pkg::SQ_STEPS; k++) begin
				sq_side_q[k] <= sq_side_q[k-1];
			end
			dv_side_q[0] <= side_d;
			for (int k = 1; k < vfa_pkg::DIV_STEPS; k++) begin
				dv_side_q[k] <= dv_side_q[k-1];
			end
		end
	end

	always_comb begin
		side_d      = sq_side_q[vfa_pkg::SQ_STEPS-1];
		side_d.root = root;
		fx          = vfa_pkg::DEN_W'($signed(side_d.f));
		if (side_d.mode == vfa_pkg::MODE_DIV) begin
			den = fx[vfa_pkg::DEN_W-1] ? vfa_pkg::DEN_W'(-fx) : vfa_pkg::DEN_W'(fx);
		end else begin
			den = root;
		end
	end

	for (genvar i = 0; i < NL; i++) begin : g_div
		logic signed [vfa_pkg::COMP_W:0] ax;
		logic [vfa_pkg::COMP_W-1:0]      amag;
		logic                            neg;

		always_comb begin
			ax   = (vfa_pkg::COMP_W+1)'($signed(side_d.a[i]));
			amag = ax[vfa_pkg::COMP_W] ? vfa_pkg::COMP_W'(-ax) : vfa_pkg::COMP_W'(ax);
			neg  = side_d.a[i][vfa_pkg::COMP_W-1]
				^ ((side_d.mode == vfa_pkg::MODE_DIV) && side_d.f[vfa_pkg::COMP_W-1]);
		end

		vfa_div u_div (
			.clk  (clk),
			.en   (en),
			.num  ({amag, {vfa_pkg::FRAC_W{1'b0}}}),
			.den  (den),
			.neg  (neg),
			.quot (quot[i])
		);
	end

	always_comb begin
		side_f     = dv_side_q[vfa_pkg::DIV_STEPS-1];
		fin.r      = side_f.res;
		fin.scalar = side_f.scalar;
		fin.eq     = side_f.eq;
		fin.derr   = 1'b0;
		case (side_f.mode)
			vfa_pkg::MODE_DIV: begin
				if (side_f.f == '0) begin
					fin.derr = 1'b1;
					fin.r    = '0;
				end else begin
					for (int i = 0; i < NL; i++) fin.r[i] = quot[i];
				end
			end
			vfa_pkg::MODE_NORM: begin
				if (side_f.root == '0) begin
					fin.r = side_f.a;
				end else begin
					for (int i = 0; i < NL; i++) fin.r[i] = quot[i];
				end
			end
			vfa_pkg::MODE_LEN: begin
				fin.scalar = vfa_pkg::sat_c(vfa_pkg::WIDE_W'($signed({1'b0, side_f.root})));
			end
			default: begin
			end
		endcase
	end

	assign produce = en && dv_vld_q[vfa_pkg::DIV_STEPS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || !out_stall) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= produce;
			end
		end else if (produce) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || !out_stall) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (produce) begin
				out_q <= fin;
			end
		end else if (produce) begin
			skid_q <= fin;
		end
	end

	assign out_valid  = out_vld_q;
	assign r_x        = out_q.r[0];
	assign r_y        = out_q.r[1];
	assign r_z        = out_q.r[2];
	assign scalar_out = out_q.scalar;
	assign equal_flag = out_q.eq;
	assign div_error  = out_q.derr;

	`ASSERT_CLK(a_skid_needs_out, clk, arst_n, !skid_vld_q || out_vld_q, "skid full while output empty")
	`ASSERT_NEXT(a_skid_drains, clk, arst_n, skid_vld_q && !out_stall, out_vld_q, "skid item lost")
	`ASSERT_CLK(a_div_err_zero, clk, arst_n, !(out_vld_q && div_error) || (r_x == '0 && r_y == '0 && r_z == '0), "divide error with nonzero vector")
	`ASSERT_CLK(a_eq_alone, clk, arst_n, !(out_vld_q && equal_flag) || (scalar_out == '0 && !div_error), "compare result mixed with other fields")

endmodule
